[rtl/core/bb3_pkg.sv]
package bb3_pkg;

  localparam int unsigned MaxLineDefault = 4096;
  localparam int unsigned RowLimit       = 4096;
  localparam int unsigned CfgW           = 13;
  localparam int unsigned PixW           = 24;
  localparam int unsigned SumW           = 12;   // 9 * 255 fits in 12 bits

  typedef enum logic [0:0] {
    RegLineLength = 1'b0,
    RegLineCount  = 1'b1
  } reg_idx_e;

  // One window column, top to bottom.
  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] bot;
  } win_col_t;

  // Which rows of a column lie inside the frame, and whether the column does.
  typedef struct packed {
    logic col_in;
    logic top_in;
    logic bot_in;
  } edge_mask_t;

  // Reciprocal scale for divisors 1, 2, 3, 4, 6 and 9, 12-bit dividends, 16-bit shift.
  function automatic logic [16:0] recip(input logic [3:0] n);
    logic [16:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/box_blur_3x3_edge_adaptive.sv]
// 3x3 box blur with edge-adaptive normalization, RGB, raster order.
//
// Input channel (in_valid_i/in_ready_o): one request per pixel (action_i=0)
// or drain tick (action_i=1). Output channel (out_valid_o/out_ready_i):
// zero or one result per request; the result for raster position k comes
// with the request that brings position k + line_length + 1, so after the
// last pixel line_length + 1 drain requests flush the frame. frame_end_o
// marks the last pixel. Drains before the frame is complete give nothing.
//
// Stage one of a request reads both line stores (one registered-read RAM
// port each); stage two shifts the window cells, adds the masked column
// sums, scales by a reciprocal of the neighbor count and loads the output
// register. No new request is taken while stage two is pending. When a
// request yields a result, out_valid_o rises as stage two completes.
// While a result waits on out_ready_i, in_ready_o stays low, so a stalled
// receiver holds off every new request.
//
// Reset clears counters, window and output valid; line stores hold garbage
// but it is only read outside the frame. An APB write restarts the frame.
module box_blur_3x3_edge_adaptive
  import bb3_pkg::*;
#(
  parameter int unsigned MAX_LINE = bb3_pkg::MaxLineDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        frame_end_o
);

  localparam int unsigned AW = $clog2(MAX_LINE);
  localparam int unsigned CW = AW + 1;

  // ---------------- configuration ----------------
  logic [CfgW-1:0] len_reg_q, cnt_reg_q;
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (reg_idx_e'(paddr[2]))
      RegLineLength: prdata = 32'(len_reg_q);
      RegLineCount:  prdata = 32'(cnt_reg_q);
      default:       prdata = '0;
    endcase
  end

  // effective dimensions (0 acts as 1, clamp to max)
  logic [CW-1:0]   len;
  logic [CfgW-1:0] rows;
  always_comb begin
    if (len_reg_q == '0) len = CW'(1);
    else if (32'(len_reg_q) > MAX_LINE) len = CW'(MAX_LINE);
    else len = CW'(len_reg_q);
    if (cnt_reg_q == '0) rows = CfgW'(1);
    else if (32'(cnt_reg_q) > RowLimit) rows = CfgW'(RowLimit);
    else rows = cnt_reg_q;
  end

  // ---------------- request control ----------------
  logic            busy_q;       // stage two pending
  logic [AW-1:0]   icol_q;
  logic [CfgW-1:0] irow_q;
  logic            drop;
  logic [PixW-1:0] px_q;
  logic [AW-1:0]   s_col_q;
  logic [CfgW-1:0] s_row_q;
  logic            out_hold;
  logic            in_acc;

  // ready when stage two is free and the output register can take a result
  assign out_hold   = out_valid_o && !out_ready_i;
  assign in_ready_o = !busy_q && !out_hold;
  assign in_acc     = in_valid_i && in_ready_o;
  assign drop       = (irow_q < rows) && action_i;

  logic go;  // request that advances the pipeline
  assign go = in_acc && !drop;

  logic [PixW-1:0] upper_rd, middle_rd;
  logic [PixW-1:0] px_now;
  assign px_now = (irow_q < rows) ? {red_in_i, green_in_i, blue_in_i} : '0;

  // stage two writes back the line stores at the same address
  bb3_ram #(.Width(PixW), .Depth(MAX_LINE)) u_upper (
    .clk_i, .we_i(busy_q), .addr_i(busy_q ? s_col_q : icol_q),
    .wdata_i(middle_rd), .rdata_o(upper_rd)
  );
  bb3_ram #(.Width(PixW), .Depth(MAX_LINE)) u_middle (
    .clk_i, .we_i(busy_q), .addr_i(busy_q ? s_col_q : icol_q),
    .wdata_i(px_q), .rdata_o(middle_rd)
  );

  // ---------------- window cells ----------------
  win_col_t   c2_in, c2;
  edge_mask_t m0, m1, m2;
  logic [9:0] sr [3], sg [3], sb [3];
  logic [1:0] cn [3];
  assign c2_in = '{top: upper_rd, mid: middle_rd, bot: px_q};

  // output position
  logic [AW-1:0]   ocol;
  logic [CfgW-1:0] orow;
  logic            emit;
  always_comb begin
    emit = 1'b0;
    ocol = '0;
    orow = '0;
    if (s_col_q != '0) begin
      emit = s_row_q >= CfgW'(1);
      ocol = s_col_q - AW'(1);
      orow = s_row_q - CfgW'(1);
    end else begin
      emit = s_row_q >= CfgW'(2);
      ocol = AW'(len - CW'(1));
      orow = s_row_q - CfgW'(2);
    end
  end

  logic top_in, bot_in;
  assign top_in = orow != '0;
  assign bot_in = (orow + CfgW'(1)) < rows;
  assign m0 = '{col_in: ocol != '0, top_in: top_in, bot_in: bot_in};
  assign m1 = '{col_in: 1'b1, top_in: top_in, bot_in: bot_in};
  assign m2 = '{col_in: (CW'(ocol) + CW'(1)) < len, top_in: top_in, bot_in: bot_in};

  // u_c2 holds the previous new column (middle of the window), u_c1 the one
  // before it (left column); both shift as stage two completes.
  bb3_cell u_c2 (.clk_i, .rst_ni, .shift_i(busy_q), .col_i(c2_in), .mask_i(m1),
    .col_o(c2), .sum_r_o(sr[1]), .sum_g_o(sg[1]), .sum_b_o(sb[1]), .cnt_o(cn[1]));
  bb3_cell u_c1 (.clk_i, .rst_ni, .shift_i(busy_q), .col_i(c2), .mask_i(m0),
    .col_o(), .sum_r_o(sr[0]), .sum_g_o(sg[0]), .sum_b_o(sb[0]), .cnt_o(cn[0]));

  // Right column comes straight from stage-one data (the new column).
  logic [PixW-1:0] nt, nm, nb;
  always_comb begin
    nt = (m2.col_in && top_in) ? upper_rd : '0;
    nm = m2.col_in ? middle_rd : '0;
    nb = (m2.col_in && bot_in) ? px_q : '0;
    sr[2] = 10'(nt[23:16]) + 10'(nm[23:16]) + 10'(nb[23:16]);
    sg[2] = 10'(nt[15:8]) + 10'(nm[15:8]) + 10'(nb[15:8]);
    sb[2] = 10'(nt[7:0]) + 10'(nm[7:0]) + 10'(nb[7:0]);
    cn[2] = m2.col_in ? (2'd1 + 2'(top_in) + 2'(bot_in)) : 2'd0;
  end

  logic [SumW-1:0] tr, tg, tb;
  logic [3:0]      tc;
  logic [16:0]     rc;
  logic [28:0]     pr, pg, pb;
  always_comb begin
    tr = SumW'(sr[0]) + SumW'(sr[1]) + SumW'(sr[2]);
    tg = SumW'(sg[0]) + SumW'(sg[1]) + SumW'(sg[2]);
    tb = SumW'(sb[0]) + SumW'(sb[1]) + SumW'(sb[2]);
    tc = 4'(cn[0]) + 4'(cn[1]) + 4'(cn[2]);
    rc = recip(tc);
    pr = 29'(tr) * 29'(rc);
    pg = 29'(tg) * 29'(rc);
    pb = 29'(tb) * 29'(rc);
  end

  logic last;
  assign last = (orow == rows - CfgW'(1)) && (CW'(ocol) == len - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_reg_q   <= CfgW'(MaxLineDefault);
      cnt_reg_q   <= CfgW'(RowLimit);
      busy_q      <= 1'b0;
      icol_q      <= '0;
      irow_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cfg_wr) begin
        case (reg_idx_e'(paddr[2]))
          RegLineLength: len_reg_q <= pwdata[CfgW-1:0];
          RegLineCount:  cnt_reg_q <= pwdata[CfgW-1:0];
          default: ;
        endcase
        icol_q <= '0;
        irow_q <= '0;
      end
      busy_q <= go;
      if (go) begin
        if (CW'(icol_q) + CW'(1) >= len) begin
          icol_q <= '0;
          irow_q <= irow_q + CfgW'(1);
        end else begin
          icol_q <= icol_q + AW'(1);
        end
      end
      if (busy_q && emit) begin
        out_valid_o <= 1'b1;
        if (last) begin
          icol_q <= '0;
          irow_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      px_q    <= px_now;
      s_col_q <= (CW'(icol_q) >= len) ? '0 : icol_q;
      s_row_q <= irow_q;
    end
    if (busy_q && emit) begin
      out_red_o   <= pr[23:16];
      out_green_o <= pg[23:16];
      out_blue_o  <= pb[23:16];
      frame_end_o <= last;
    end
  end

  // ---------------- checks ----------------
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_ready_o) else $error("accept during stage two");
  a_stage_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> busy_q) else $error("stage two missing");
  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(busy_q)) else $error("result without request");

endmodule

[rtl/core/bb3_ram.sv]
module bb3_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/core/bb3_cell.sv]
// One window column cell: holds a column of three pixels, shifts it to the
// left neighbor every step and yields its masked per-channel partial sum.
module bb3_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     shift_i,
  input  bb3_pkg::win_col_t        col_i,
  input  bb3_pkg::edge_mask_t      mask_i,
  output bb3_pkg::win_col_t        col_o,
  output logic [9:0]               sum_r_o,
  output logic [9:0]               sum_g_o,
  output logic [9:0]               sum_b_o,
  output logic [1:0]               cnt_o
);
  import bb3_pkg::*;

  win_col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

  logic [PixW-1:0] t, m, b;
  always_comb begin
    t = (mask_i.col_in && mask_i.top_in) ? col_q.top : '0;
    m = mask_i.col_in ? col_q.mid : '0;
    b = (mask_i.col_in && mask_i.bot_in) ? col_q.bot : '0;
    sum_r_o = 10'(t[23:16]) + 10'(m[23:16]) + 10'(b[23:16]);
    sum_g_o = 10'(t[15:8]) + 10'(m[15:8]) + 10'(b[15:8]);
    sum_b_o = 10'(t[7:0]) + 10'(m[7:0]) + 10'(b[7:0]);
    cnt_o = mask_i.col_in ? (2'd1 + 2'(mask_i.top_in) + 2'(mask_i.bot_in)) : 2'd0;
  end

endmodule

[tb/box_blur_3x3_edge_adaptive_tb.sv]
`timescale 1ns / 1ps

module box_blur_3x3_edge_adaptive_tb;
  import bb3_pkg::*;

  localparam int unsigned LineMax = 4096;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } blur_px_t;

  // Holds the blur predictor state and the queue of pending blurred pixels.
  class blur_scoreboard;
    logic [23:0] upper_row[LineMax];
    logic [23:0] middle_row[LineMax];
    logic [23:0] win[9];
    int unsigned in_col, in_row;
    int unsigned cfg_len, cfg_rows;
    blur_px_t    pending_px[$];
    int          n_errors;

    function new();
      foreach (win[i]) win[i] = '0;
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      cfg_len   = 4096;
      cfg_rows  = 4096;
      in_col    = 0;
      in_row    = 0;
      n_errors  = 0;
    endfunction

    function void restart();
      in_col = 0;
      in_row = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [12:0] val);
      if (idx == RegLineLength) cfg_len = val;
      else cfg_rows = val;
      restart();
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // Note an accepted request; push the blurred pixel it releases, if any.
    function void note_request(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned len, rows, col, row, sr, sg, sb, cnt;
      logic [23:0] px, top, mid;
      int orow, ocol, rr, cc;
      blur_px_t res;
      len  = clamp(cfg_len, LineMax);
      rows = clamp(cfg_rows, RowLimit);
      px   = '0;
      if (in_row < rows) begin
        if (act) return;  // drain ahead of a complete frame does nothing
        px = {r, g, b};
      end
      col = in_col;
      row = in_row;
      if (col >= len) col = 0;
      top = upper_row[col];
      mid = middle_row[col];
      upper_row[col]  = mid;
      middle_row[col] = px;
      for (int i = 0; i < 3; i++) begin
        win[i*3]   = win[i*3+1];
        win[i*3+1] = win[i*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      if (col + 1 >= len) begin
        in_col = 0;
        in_row = row + 1;
      end else begin
        in_col = col + 1;
      end
      if (col >= 1) begin
        if (row < 1) return;
        orow = row - 1;
        ocol = col - 1;
      end else begin
        if (row < 2) return;
        orow = row - 2;
        ocol = len - 1;
      end
      sr = 0; sg = 0; sb = 0; cnt = 0;
      for (int dr = 0; dr < 3; dr++) begin
        for (int dc = 0; dc < 3; dc++) begin
          rr = orow - 1 + dr;
          cc = ocol - 1 + dc;
          if (rr >= 0 && rr < int'(rows) && cc >= 0 && cc < int'(len)) begin
            sr += win[dr*3+dc][23:16];
            sg += win[dr*3+dc][15:8];
            sb += win[dr*3+dc][7:0];
            cnt++;
          end
        end
      end
      if (cnt == 0) cnt = 1;
      res.red       = sr / cnt;
      res.green     = sg / cnt;
      res.blue      = sb / cnt;
      res.frame_end = (orow == int'(rows) - 1 && ocol == int'(len) - 1);
      if (res.frame_end) restart();
      pending_px.push_back(res);
    endfunction

    function void check_px(blur_px_t got);
      blur_px_t exp_px;
      if (pending_px.size() == 0) begin
        report("unexpected output pixel", 0, got);
        return;
      end
      exp_px = pending_px.pop_front();
      if (got.red != exp_px.red) report("out_red", exp_px.red, got.red);
      if (got.green != exp_px.green) report("out_green", exp_px.green, got.green);
      if (got.blue != exp_px.blue) report("out_blue", exp_px.blue, got.blue);
      if (got.frame_end != exp_px.frame_end)
        report("frame_end", exp_px.frame_end, got.frame_end);
    endfunction

    function void report(string what, longint unsigned exp_v, longint unsigned got_v);
      $display("MISMATCH %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
      n_errors++;
    endfunction
  endclass

  logic        clk, rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_ready, action;
  logic [7:0]  red_in, green_in, blue_in;
  logic        out_valid, out_ready;
  logic [7:0]  out_red, out_green, out_blue;
  logic        frame_end;

  blur_scoreboard sb;
  bit  rx_idle_ok;    // random receiver stalls enabled
  bit  tx_idle_ok;    // random sender gaps enabled
  int  hold_off;      // cycles the receiver is forced to stall

  box_blur_3x3_edge_adaptive dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .red_in_i    (red_in),
    .green_in_i  (green_in),
    .blue_in_i   (blue_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_red_o   (out_red),
    .out_green_o (out_green),
    .out_blue_o  (out_blue),
    .frame_end_o (frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stall bursts, a forced long hold-off when requested.
  initial begin
    int burst;
    out_ready = 1'b0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_px({out_red, out_green, out_blue, frame_end});
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready <= 1'b0;
      end else if (rx_idle_ok && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Single APB register write; setup then access phase, then the bus goes idle.
  task automatic write_reg(reg_idx_e idx, logic [12:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx) << 2;
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request, optionally after a random gap; returns after accept.
  task automatic send_req(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (tx_idle_ok && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_request(act, r, g, b);
  endtask

  task automatic send_rand_px();
    send_req(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Full frame of random pixels with random drains mixed in, then enough drains to flush it.
  task automatic run_frame(int unsigned len, int unsigned rows);
    for (int i = 0; i < len * rows; i++) begin
      if ($urandom_range(0, 15) == 0) send_req(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
      send_rand_px();
    end
    for (int i = 0; i <= len; i++) begin
      send_req($urandom_range(0, 3) != 0, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Quiesce, then let the block finish any request that makes no output.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_frame(logic [12:0] len, logic [12:0] rows);
    settle();
    write_reg(RegLineLength, len);
    write_reg(RegLineCount, rows);
  endtask

  initial begin
    int unsigned len, rows, sent;
    sb = new();
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; action = 1'b0; red_in = '0; green_in = '0; blue_in = '0;
    rx_idle_ok = 1'b0;
    tx_idle_ok = 1'b0;
    hold_off = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 3x3 frame with extreme pixels and an early drain.
    set_frame(13'd3, 13'd3);
    send_req(1'b1, 8'hff, 8'hff, 8'hff);   // drain before frame complete
    send_req(1'b0, 8'hff, 8'h00, 8'hff);
    send_req(1'b0, 8'h00, 8'hff, 8'h00);
    send_req(1'b0, 8'hff, 8'hff, 8'hff);
    send_req(1'b0, 8'h00, 8'h00, 8'h00);
    send_req(1'b0, 8'hff, 8'hff, 8'hff);
    send_req(1'b0, 8'h55, 8'haa, 8'h01);
    send_req(1'b0, 8'haa, 8'h55, 8'h80);
    send_req(1'b0, 8'hff, 8'hff, 8'hff);
    send_req(1'b0, 8'hfe, 8'h7f, 8'hff);
    send_req(1'b0, 8'h12, 8'h34, 8'h56);   // pixel past frame acts as a drain
    repeat (3) send_req(1'b1, 8'h00, 8'h00, 8'h00);
    // Degenerate sizes: zero acts as one, single row and single column.
    set_frame(13'd0, 13'd0);
    run_frame(1, 1);
    set_frame(13'd1, 13'd4);
    run_frame(1, 4);
    set_frame(13'd5, 13'd1);
    run_frame(5, 1);

    // Random frames with idling on both sides.
    rx_idle_ok = 1'b1;
    tx_idle_ok = 1'b1;
    sent = 0;
    while (sent < 1450) begin
      len  = $urandom_range(1, 8);
      rows = $urandom_range(1, 6);
      set_frame(13'(len), 13'(rows));
      if (sent == 0) begin
        hold_off = 200;   // fill the pipe while the receiver stalls
      end
      run_frame(len, rows);
      sent += len * rows + len + 1;
    end
    // Out-of-range registers clamp to the maximum: exercise top bits.
    set_frame(13'h1fff, 13'd1);
    for (int i = 0; i < 20; i++) send_rand_px();
    set_frame(13'd2, 13'h1fff);
    for (int i = 0; i < 20; i++) send_rand_px();
    set_frame(13'd4096, 13'd2);
    for (int i = 0; i < 10; i++) send_rand_px();

    // Final stretch, no idling.
    set_frame(13'd6, 13'd5);
    rx_idle_ok = 1'b0;
    tx_idle_ok = 1'b0;
    run_frame(6, 5);
    in_valid <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.n_errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
